FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands for the checker file. Each expects a clock named
// clk and an active-low reset named rst_n in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SFK_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SFK_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/sfk_pkg.sv
// ----------------------------------------------------------------------------
// sfk_pkg
// Types and fixed constants of the square-free kernel block.
// ----------------------------------------------------------------------------
`default_nettype none

package sfk_pkg;

    // The even prime is handled by shifting; odd trial divisors start here.
    localparam int unsigned PRIME_TWO   = 2;
    localparam int unsigned FIRST_ODD   = 3;
    localparam int unsigned ODD_STEP    = 2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TWO,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_MUL_START,
        ST_MUL_WAIT,
        ST_FINISH,
        ST_DONE
    } sfk_state_t;

    // Command from the sequencer to the arithmetic unit.
    typedef struct packed {
        logic start;
        logic mul;
    } sfk_cmd_t;

    // Status from the arithmetic unit back to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } sfk_stat_t;

endpackage

`default_nettype wire

FILE: design/square_free_kernel.sv
// ----------------------------------------------------------------------------
// square_free_kernel
// Square-free kernel of an unsigned integer by trial division.
// ----------------------------------------------------------------------------
// Usage: a value beat arrives on the s_axis group; the kernel (product of the
// primes that divide the value an odd number of times) leaves on the m_axis
// group, one result beat per input beat, in order. A zero value gives zero.
// The block works on one value at a time and holds s_axis_tready low until
// the value is finished. Factors of two are shifted out, one per cycle. Each
// odd trial divisor then costs one division in the shared bit-serial unit
// and one more each time it divides the value, and every odd prime kept in
// the kernel adds a serial multiplication. Latency therefore grows with the
// number of odd trial divisors tried, about sqrt(v) / 2 of them in the worst
// case. The result sits in an output register; a stalled receiver holds it
// there, and a new value is taken meanwhile but the next result waits until
// the register has been emptied.
// Reset clears the sequencer and the output valid; no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module square_free_kernel #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   s_axis_tdata,   // value
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    output logic [((VALUE_WIDTH+7)/8)*8-1:0]        m_axis_tdata    // kernel
);

    localparam int W       = VALUE_WIDTH;
    localparam int TDATA_W = ((VALUE_WIDTH + 7) / 8) * 8;

    sfk_pkg::sfk_state_t state_reg, state_next;

    logic [W-1:0] rem_reg,    rem_next;
    logic [W-1:0] prod_reg,   prod_next;
    logic [W-1:0] cand_reg,   cand_next;
    logic         parity_reg, parity_next;
    logic         first_reg,  first_next;
    logic         last_reg,   last_next;
    logic         ovalid_reg, ovalid_next;
    logic [W-1:0] kernel_reg, kernel_next;

    sfk_pkg::sfk_cmd_t  cmd;
    sfk_pkg::sfk_stat_t stat;
    logic [W-1:0]       op_a;
    logic [W-1:0]       op_b;
    logic [W-1:0]       unit_res;
    logic [W-1:0]       unit_rem;

    logic         in_take;
    logic         out_free;
    logic [W-1:0] value;

    assign value    = s_axis_tdata[W-1:0];
    assign in_take  = s_axis_tvalid && s_axis_tready;
    assign out_free = !ovalid_reg || m_axis_tready;

    sfk_arith #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_arith (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .op_a      (op_a),
        .op_b      (op_b),
        .stat      (stat),
        .result    (unit_res),
        .remainder (unit_rem)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sfk_pkg::ST_IDLE:
            begin
                if (in_take)
                    state_next = (value == '0) ? sfk_pkg::ST_DONE : sfk_pkg::ST_TWO;
            end
            sfk_pkg::ST_TWO:
            begin
                if (rem_reg[0])
                    state_next = sfk_pkg::ST_DIV_START;
            end
            sfk_pkg::ST_DIV_START:
                state_next = sfk_pkg::ST_DIV_WAIT;
            sfk_pkg::ST_DIV_WAIT:
            begin
                if (stat.done)
                begin
                    if (first_reg && (cand_reg > unit_res))
                        state_next = sfk_pkg::ST_FINISH;
                    else if (unit_rem == '0)
                        state_next = sfk_pkg::ST_DIV_START;
                    else if (parity_reg)
                        state_next = sfk_pkg::ST_MUL_START;
                    else
                        state_next = sfk_pkg::ST_DIV_START;
                end
            end
            sfk_pkg::ST_MUL_START:
                state_next = sfk_pkg::ST_MUL_WAIT;
            sfk_pkg::ST_MUL_WAIT:
            begin
                if (stat.done)
                    state_next = last_reg ? sfk_pkg::ST_DONE : sfk_pkg::ST_DIV_START;
            end
            sfk_pkg::ST_FINISH:
            begin
                if (rem_reg > W'(1))
                    state_next = sfk_pkg::ST_MUL_START;
                else
                    state_next = sfk_pkg::ST_DONE;
            end
            sfk_pkg::ST_DONE:
            begin
                if (out_free)
                    state_next = sfk_pkg::ST_IDLE;
            end
            default:
                state_next = sfk_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        s_axis_tready = (state_reg == sfk_pkg::ST_IDLE);
        cmd.start     = (state_reg == sfk_pkg::ST_DIV_START) ||
                        (state_reg == sfk_pkg::ST_MUL_START);
        cmd.mul       = (state_reg == sfk_pkg::ST_MUL_START);
        if (state_reg == sfk_pkg::ST_MUL_START)
        begin
            op_a = prod_reg;
            op_b = last_reg ? rem_reg : cand_reg;
        end
        else
        begin
            op_a = rem_reg;
            op_b = cand_reg;
        end
    end

    // Datapath registers.
    always_comb
    begin
        rem_next    = rem_reg;
        prod_next   = prod_reg;
        cand_next   = cand_reg;
        parity_next = parity_reg;
        first_next  = first_reg;
        last_next   = last_reg;
        ovalid_next = ovalid_reg && !m_axis_tready;
        kernel_next = kernel_reg;
        case (state_reg)
            sfk_pkg::ST_IDLE:
            begin
                if (in_take)
                begin
                    rem_next    = value;
                    prod_next   = '0;
                    parity_next = 1'b0;
                    last_next   = 1'b0;
                end
            end
            sfk_pkg::ST_TWO:
            begin
                if (!rem_reg[0])
                begin
                    rem_next    = {1'b0, rem_reg[W-1:1]};
                    parity_next = !parity_reg;
                end
                else
                begin
                    prod_next   = parity_reg ? W'(sfk_pkg::PRIME_TWO) : W'(1);
                    cand_next   = W'(sfk_pkg::FIRST_ODD);
                    parity_next = 1'b0;
                    first_next  = 1'b1;
                end
            end
            sfk_pkg::ST_DIV_WAIT:
            begin
                // The loop bound is checked only on the first division by
                // each candidate, against the remaining value as it then was.
                if (stat.done && !(first_reg && (cand_reg > unit_res)))
                begin
                    if (unit_rem == '0)
                    begin
                        rem_next    = unit_res;
                        parity_next = !parity_reg;
                        first_next  = 1'b0;
                    end
                    else if (!parity_reg)
                    begin
                        cand_next  = cand_reg + W'(sfk_pkg::ODD_STEP);
                        first_next = 1'b1;
                    end
                end
            end
            sfk_pkg::ST_MUL_WAIT:
            begin
                if (stat.done)
                begin
                    prod_next   = unit_res;
                    cand_next   = cand_reg + W'(sfk_pkg::ODD_STEP);
                    parity_next = 1'b0;
                    first_next  = 1'b1;
                end
            end
            sfk_pkg::ST_FINISH:
            begin
                if (rem_reg > W'(1))
                    last_next = 1'b1;
            end
            sfk_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    ovalid_next = 1'b1;
                    kernel_next = prod_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= sfk_pkg::ST_IDLE;
            ovalid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            ovalid_reg <= ovalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        prod_reg   <= prod_next;
        cand_reg   <= cand_next;
        parity_reg <= parity_next;
        first_reg  <= first_next;
        last_reg   <= last_next;
        kernel_reg <= kernel_next;
    end

    assign m_axis_tvalid = ovalid_reg;
    assign m_axis_tdata  = TDATA_W'(kernel_reg);

endmodule

`default_nettype wire

FILE: design/sfk_arith.sv
// ----------------------------------------------------------------------------
// sfk_arith
// Shared bit-serial arithmetic unit: restoring division (one quotient bit per
// cycle) and shift-and-add multiplication (one multiplier bit per cycle), both
// built around a single adder.
// ----------------------------------------------------------------------------
`default_nettype none

module sfk_arith #(
    parameter int VALUE_WIDTH = 31
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire sfk_pkg::sfk_cmd_t      cmd,
    input  wire logic [VALUE_WIDTH-1:0] op_a,     // dividend or multiplicand
    input  wire logic [VALUE_WIDTH-1:0] op_b,     // divisor or multiplier
    output sfk_pkg::sfk_stat_t          stat,
    output logic [VALUE_WIDTH-1:0]      result,   // quotient or product
    output logic [VALUE_WIDTH-1:0]      remainder
);

    localparam int W     = VALUE_WIDTH;
    localparam int AW    = W + 2;
    localparam int CNT_W = $clog2(W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic             mode_reg, mode_next;
    logic [CNT_W-1:0] cnt_reg,  cnt_next;
    logic [W-1:0]     hi_reg,   hi_next;
    logic [W-1:0]     lo_reg,   lo_next;
    logic [W-1:0]     b_reg,    b_next;

    logic [W:0]       add_a;
    logic [W:0]       add_b;
    logic             add_sub;
    logic [AW-1:0]    sum;
    logic             last_step;

    // The one adder; in subtract mode its top bit flags a borrow.
    always_comb
    begin
        if (mode_reg)
        begin
            add_a   = {1'b0, hi_reg};
            add_b   = {1'b0, b_reg};
            add_sub = 1'b0;
        end
        else
        begin
            add_a   = {hi_reg, lo_reg[W-1]};
            add_b   = {1'b0, b_reg};
            add_sub = 1'b1;
        end
        sum = {1'b0, add_a} + (add_sub ? ~{1'b0, add_b} : {1'b0, add_b}) + AW'(add_sub);
    end

    always_comb
    begin
        if (mode_reg)
            last_step = (lo_reg[W-1:1] == '0);
        else
            last_step = (cnt_reg == CNT_W'(W - 1));
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        if (cmd.start && !busy_reg)
        begin
            busy_next = 1'b1;
            mode_next = cmd.mul;
            cnt_next  = '0;
            hi_next   = '0;
            lo_next   = cmd.mul ? op_b : op_a;
            b_next    = cmd.mul ? op_a : op_b;
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg + CNT_W'(1);
            if (mode_reg)
            begin
                if (lo_reg[0])
                    hi_next = sum[W-1:0];
                lo_next = {1'b0, lo_reg[W-1:1]};
                b_next  = {b_reg[W-2:0], 1'b0};
            end
            else
            begin
                // A clear borrow bit means the divisor fits: keep the difference.
                if (!sum[AW-1])
                begin
                    hi_next = sum[W-1:0];
                    lo_next = {lo_reg[W-2:0], 1'b1};
                end
                else
                begin
                    hi_next = add_a[W-1:0];
                    lo_next = {lo_reg[W-2:0], 1'b0};
                end
            end
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            mode_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            mode_reg <= mode_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign result    = mode_reg ? hi_reg : lo_reg;
    assign remainder = hi_reg;

endmodule

`default_nettype wire

FILE: design/sfk_checker.sv
// ----------------------------------------------------------------------------
// sfk_checker
// Port-level checks of the square-free kernel block, bound to its top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sfk_checker #(
    parameter int VALUE_WIDTH = 31
) (
    input wire logic                               clk,
    input wire logic                               rst_n,
    input wire logic                               s_axis_tvalid,
    input wire logic                               s_axis_tready,
    input wire logic                               m_axis_tvalid,
    input wire logic                               m_axis_tready,
    input wire logic [((VALUE_WIDTH+7)/8)*8-1:0]   m_axis_tdata    // kernel
);

    // A stalled result beat must stay put.
    `SFK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result beat changed while stalled")

    // The block works on one value at a time, so it closes its input at once.
    `SFK_ASSERT_NEXT(a_busy_after_take, s_axis_tvalid && s_axis_tready, !s_axis_tready, "input still open after a beat was taken")

    // A result is loaded only as the sequencer returns to idle.
    `SFK_ASSERT_SAME(a_result_at_idle, $rose(m_axis_tvalid), s_axis_tready, "result appeared while a value was still in work")

    // The tdata of a result beat changes only when a new beat is loaded.
    `SFK_ASSERT_SAME(a_data_with_load, !$stable(m_axis_tdata) && $past(rst_n), m_axis_tvalid && s_axis_tready, "result data changed outside a load")

endmodule

bind square_free_kernel sfk_checker #(
    .VALUE_WIDTH (VALUE_WIDTH)
) u_sfk_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

FILE: dv/tb_square_free_kernel.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_square_free_kernel
// Self-checking bench for the square-free kernel block.
// ----------------------------------------------------------------------------
// Values go in as beats on the slave side. A behavioural trial-division
// predictor works out the kernel of each accepted value and queues it. Every
// result beat is checked against the oldest queued kernel. The run has three
// parts: a directed set of corner values that ends with the slowest value of
// all, a long receiver hold-off, and random values under three idling mixes.
// Random values are kept mostly smooth or small so that the run stays short.
// ----------------------------------------------------------------------------

module tb_square_free_kernel;

    localparam int VALUE_WIDTH     = 31;
    localparam int DATA_WIDTH      = ((VALUE_WIDTH + 7) / 8) * 8;
    localparam longint VALUE_MAX   = (longint'(1) << VALUE_WIDTH) - 1;
    localparam int HOLD_CYCLES     = 2500;
    localparam int TAIL_CYCLES     = 200;
    // The slowest value (a prime near the top of the range) moves no beat for
    // its whole run, so this limit must exceed the length of that run.
    localparam int WATCHDOG_LIMIT  = 4000000;

    localparam logic [DATA_WIDTH-1:0] CORNER_BEATS [20] = '{
        32'd0,          32'd1,          32'd2,          32'd3,
        32'd4,          32'd8,          32'd12,         32'd18,
        32'd30,         32'd36,         32'd49,         32'd97,
        32'd65521,      32'd223092870,  32'd1073741823, 32'd1073741824,
        32'd1610612736, 32'd2147395600, 32'h8000_000C,  32'd2147483647
    };

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [DATA_WIDTH-1:0] s_axis_tdata = '0;    // value
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [DATA_WIDTH-1:0] m_axis_tdata;         // kernel

    logic [VALUE_WIDTH-1:0] pending_kernels [$];
    int                     mismatch_count = 0;
    int                     sender_idle_pct = 0;
    int                     receiver_idle_pct = 0;
    logic                   hold_trigger = 1'b0;
    logic                   hold_seen = 1'b0;
    int                     hold_left = 0;
    int                     quiet_cycles = 0;

    square_free_kernel #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Trial division with the square bound applied from the first divisor on.
    // Once the candidate squared exceeds what is left, the rest is 1 or a prime.
    function automatic logic [VALUE_WIDTH-1:0] square_free_part(
        input logic [VALUE_WIDTH-1:0] value
    );
        longint unsigned rest;
        longint unsigned prod;
        longint unsigned cand;
        bit              odd_power;
        rest = value;
        prod = 1;
        cand = sfk_pkg::PRIME_TWO;
        if (rest == 0)
            return '0;
        while (cand <= rest / cand)
        begin
            odd_power = 1'b0;
            while (rest % cand == 0)
            begin
                rest      = rest / cand;
                odd_power = ~odd_power;
            end
            if (odd_power)
                prod = prod * cand;
            cand = (cand == sfk_pkg::PRIME_TWO) ? sfk_pkg::FIRST_ODD
                                                : cand + sfk_pkg::ODD_STEP;
        end
        if (rest > 1)
            prod = prod * rest;
        return prod[VALUE_WIDTH-1:0];
    endfunction

    // Random product of small primes not above the given bound.
    function automatic longint smooth_value(input longint bound);
        longint prod;
        longint prime;
        prod = 1;
        repeat ($urandom_range(1, 24))
        begin
            case ($urandom_range(0, 10))
                0:       prime = 2;
                1:       prime = 3;
                2:       prime = 5;
                3:       prime = 7;
                4:       prime = 11;
                5:       prime = 13;
                6:       prime = 17;
                7:       prime = 19;
                8:       prime = 23;
                9:       prime = 29;
                default: prime = 31;
            endcase
            if (prod * prime <= bound)
                prod = prod * prime;
        end
        return prod;
    endfunction

    task automatic send_beat(input logic [DATA_WIDTH-1:0] beat);
        while ($urandom_range(0, 99) < sender_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= beat;
        do
            @(posedge clk);
        while (!s_axis_tready);
        // Bits above the value field are padding and do not reach the kernel.
        pending_kernels.insert(pending_kernels.size(),
                               square_free_part(beat[VALUE_WIDTH-1:0]));
    endtask

    task automatic settle_results();
        s_axis_tvalid <= 1'b0;
        while (pending_kernels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_corner_values();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        foreach (CORNER_BEATS[i])
            send_beat(CORNER_BEATS[i]);
        settle_results();
    endtask

    // The receiver stops for a long stretch while values keep coming, so the
    // output register fills, one more value is taken and the input stalls.
    task automatic test_back_pressure();
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        hold_trigger <= ~hold_trigger;
        repeat (6)
            send_beat(DATA_WIDTH'($urandom_range(0, 255)));
        settle_results();
    endtask

    task automatic test_random_values(input int count, input int s_pct, input int r_pct);
        int     pick;
        longint value;
        sender_idle_pct   = s_pct;
        receiver_idle_pct = r_pct;
        repeat (count)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                value = $urandom_range(0, 4095);
            else if (pick < 75)
                value = smooth_value(VALUE_MAX);
            else
                value = smooth_value(32767) * $urandom_range(2, 16383);
            send_beat(DATA_WIDTH'(value));
        end
        settle_results();
    endtask

    initial
    begin
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_corner_values();
        test_back_pressure();
        test_random_values(34, 15, 66);
        test_random_values(33, 66, 15);
        test_random_values(33, 0, 0);
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatch_count == 0 && pending_kernels.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_trigger != hold_seen)
        begin
            hold_seen = hold_trigger;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(0, 99) >= receiver_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_kernels.size() == 0)
            begin
                $error("kernel beat with no value pending: actual %0d",
                       m_axis_tdata[VALUE_WIDTH-1:0]);
                mismatch_count++;
            end
            else if (m_axis_tdata[VALUE_WIDTH-1:0] !== pending_kernels[0])
            begin
                $error("kernel mismatch: expected %0d, actual %0d",
                       pending_kernels[0], m_axis_tdata[VALUE_WIDTH-1:0]);
                mismatch_count++;
                void'(pending_kernels.pop_front());
            end
            else
                void'(pending_kernels.pop_front());
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

endmodule
